@@ rtl/text_and_rect_quad_generator_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef TEXT_AND_RECT_QUAD_GENERATOR_UNIT_ASSERT_SVH
`define TEXT_AND_RECT_QUAD_GENERATOR_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define QGU_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define QGU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/qgu_pkg.sv @@
package qgu_pkg;

  typedef enum logic [2:0] {
    KIND_FRAME    = 3'd0,
    KIND_RECT     = 3'd1,
    KIND_TEXT     = 3'd2,
    KIND_BYTE     = 3'd3,
    KIND_CMD_END  = 3'd4,
    KIND_GLYPH_WR = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RECT,
    OP_GLYPH,
    OP_FRAME,
    OP_TEXT,
    OP_END
  } op_t;

  localparam logic [0:0]  REG_ASCENT     = 1'b0;
  localparam logic [0:0]  REG_DEPTH_STEP = 1'b1;
  localparam logic [15:0] DEPTH_START    = 16'd58982;
  localparam logic [7:0]  CHAR_QMARK     = 8'h3F;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] size_w;
    logic signed [23:0] size_h;
    logic [15:0]        tex_u0;
    logic [15:0]        tex_v0;
    logic [15:0]        tex_u1;
    logic [15:0]        tex_v1;
    logic signed [23:0] pen_advance;
    logic [7:0]         code;
    logic [31:0]        rgba;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic [15:0]        vert_z;
    logic [15:0]        vert_u;
    logic [15:0]        vert_v;
    logic               textured;
    logic [31:0]        vert_rgba;
    logic               quad_last;
  } vert_t;

  typedef struct packed {
    logic        index;
    logic [23:0] data;
  } cfg_t;

endpackage

@@ rtl/qgu_if.sv @@
interface qgu_cmd_if;
  logic           valid;
  logic           ready;
  qgu_pkg::cmd_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qgu_vert_if;
  logic           valid;
  logic           ready;
  qgu_pkg::vert_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qgu_cfg_if;
  logic           valid;
  logic           ready;
  qgu_pkg::cfg_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/text_and_rect_quad_generator_unit.sv @@
// Channel | Direction | Word
// cmd     | in        | one draw command, text byte or glyph write
// vert    | out       | one triangle vertex, six per quad
// cfg     | in        | register write (ascent, depth_step)
//
// A command is decoded and its glyph entry read as it enters stage 1, which
// forms the quad and loads the vertex emitter; the emitter shows one vertex
// per cycle while vert.ready is high. Commands that emit nothing pass at one
// per cycle unless an emitting command waits in stage 1. Reset is synchronous
// and clears control state and the glyph present bits; the glyph memory itself
// is left as it is. An output stall holds the emitter and, once the stage
// behind it is full, drops cmd.ready.
module text_and_rect_quad_generator_unit #(
  parameter int GLYPH_ENTRIES = 256,
  parameter int COORD_BITS    = 24
) (
  input logic     clk,
  input logic     rst,
  qgu_cmd_if.sink cmd,
  qgu_vert_if.source vert,
  qgu_cfg_if.sink cfg
);

  localparam int USED = (GLYPH_ENTRIES < 256) ? GLYPH_ENTRIES : 256;
  localparam int IW   = $clog2(USED);
  localparam int CB   = COORD_BITS;
  localparam int MW   = 5 * CB + 64;

  function automatic logic [CB-1:0] coord_in(input logic [23:0] v);
    logic signed [31:0] e;
    e = 32'(signed'(v));
    return CB'(e);
  endfunction

  function automatic logic [23:0] coord_out(input logic [CB-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return e[23:0];
  endfunction

  // configuration
  logic [23:0] ascent;
  logic [15:0] depth_step;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ascent     <= '0;
      depth_step <= '0;
    end else if (cfg.valid) begin
      if (cfg.data.index == qgu_pkg::REG_ASCENT) begin
        ascent <= cfg.data.data;
      end else begin
        depth_step <= cfg.data.data[15:0];
      end
    end
  end

  // glyph store
  logic [MW-1:0] gmem [USED];
  logic [MW-1:0] grd;
  logic          present [USED];

  // stage 1 and emitter state
  logic            s1_valid;
  qgu_pkg::op_t    s1_op;
  qgu_pkg::cmd_t   s1_cmd;
  logic            s1_adv;
  logic            em_valid;
  logic [2:0]      em_cnt;
  logic [CB-1:0]   em_x0, em_y0, em_w, em_h;
  logic [15:0]     em_u0, em_v0, em_u1, em_v1, em_z;
  logic            em_tex;
  logic [31:0]     em_rgba;

  logic [CB-1:0]   pen_x, pen_y;
  logic [31:0]     text_rgba;
  logic [15:0]     depth_now;
  logic [20:0]     utf8_accum, utf8_accum_next;
  logic [1:0]      utf8_pending, utf8_pending_next;

  logic accept;
  assign cmd.ready = !s1_valid || s1_adv;
  assign accept    = cmd.valid && cmd.ready;

  // UTF-8 decode and glyph choice
  logic          draw;
  logic [20:0]   cp;
  logic          hit;
  logic [IW-1:0] gidx;
  qgu_pkg::op_t  op_in;
  logic [7:0]    b;

  always_comb begin
    b                 = cmd.data.code;
    draw              = 1'b0;
    cp                = '0;
    utf8_accum_next   = utf8_accum;
    utf8_pending_next = utf8_pending;
    op_in             = qgu_pkg::OP_NONE;
    unique case (cmd.data.kind)
      qgu_pkg::KIND_FRAME: begin
        op_in             = qgu_pkg::OP_FRAME;
        utf8_accum_next   = '0;
        utf8_pending_next = '0;
      end
      qgu_pkg::KIND_RECT: op_in = qgu_pkg::OP_RECT;
      qgu_pkg::KIND_TEXT: begin
        op_in             = qgu_pkg::OP_TEXT;
        utf8_accum_next   = '0;
        utf8_pending_next = '0;
      end
      qgu_pkg::KIND_CMD_END: begin
        op_in             = qgu_pkg::OP_END;
        utf8_accum_next   = '0;
        utf8_pending_next = '0;
      end
      qgu_pkg::KIND_BYTE: begin
        if (utf8_pending != 2'd0) begin
          utf8_accum_next   = {utf8_accum[14:0], b[5:0]};
          utf8_pending_next = utf8_pending - 2'd1;
          draw              = (utf8_pending == 2'd1);
          cp                = utf8_accum_next;
        end else if (!b[7]) begin
          draw = 1'b1;
          cp   = 21'(b);
        end else if (b[7:5] == 3'b110) begin
          utf8_accum_next   = 21'(b[4:0]);
          utf8_pending_next = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          utf8_accum_next   = 21'(b[3:0]);
          utf8_pending_next = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          utf8_accum_next   = 21'(b[2:0]);
          utf8_pending_next = 2'd3;
        end else begin
          draw = 1'b1;
          cp   = 21'(qgu_pkg::CHAR_QMARK);
        end
      end
      default: ;
    endcase
    hit  = (32'(cp) < 32'(USED)) && present[cp[IW-1:0]];
    gidx = hit ? cp[IW-1:0] : IW'(qgu_pkg::CHAR_QMARK);
    if (draw && (hit || present[IW'(qgu_pkg::CHAR_QMARK)])) begin
      op_in = qgu_pkg::OP_GLYPH;
    end
  end

  logic gwrite;
  assign gwrite = accept && (cmd.data.kind == qgu_pkg::KIND_GLYPH_WR)
                  && (32'(cmd.data.code) < 32'(USED));

  always_ff @(posedge clk) begin
    if (gwrite) begin
      gmem[cmd.data.code[IW-1:0]] <= {coord_in(cmd.data.pos_x), coord_in(cmd.data.pos_y),
        coord_in(cmd.data.size_w), coord_in(cmd.data.size_h),
        cmd.data.tex_u0, cmd.data.tex_v0, cmd.data.tex_u1, cmd.data.tex_v1,
        coord_in(cmd.data.pen_advance)};
    end
    if (accept) begin
      grd <= gmem[gidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USED; i++) begin
        present[i] <= 1'b0;
      end
    end else if (gwrite) begin
      present[cmd.data.code[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      utf8_accum   <= '0;
      utf8_pending <= '0;
      s1_valid     <= 1'b0;
      s1_op        <= qgu_pkg::OP_NONE;
    end else begin
      if (accept) begin
        utf8_accum   <= utf8_accum_next;
        utf8_pending <= utf8_pending_next;
        s1_op        <= op_in;
        s1_valid     <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
    if (accept) begin
      s1_cmd <= cmd.data;
    end
  end

  // stage 1: quad forming and in-order state updates
  logic em_done, em_free, s1_emits;
  logic [CB-1:0] g_ox, g_oy, g_w, g_h, g_adv;
  logic [15:0]   g_u0, g_v0, g_u1, g_v1;

  assign {g_ox, g_oy, g_w, g_h, g_u0, g_v0, g_u1, g_v1, g_adv} = grd;
  assign em_done  = vert.ready && (em_cnt == 3'd5);
  assign em_free  = !em_valid || em_done;
  assign s1_emits = (s1_op == qgu_pkg::OP_RECT) || (s1_op == qgu_pkg::OP_GLYPH);
  assign s1_adv   = s1_valid && (!s1_emits || em_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x     <= '0;
      pen_y     <= '0;
      text_rgba <= '0;
      depth_now <= qgu_pkg::DEPTH_START;
      em_valid  <= 1'b0;
      em_cnt    <= '0;
    end else begin
      if (s1_adv && s1_emits) begin
        em_valid <= 1'b1;
        em_cnt   <= '0;
      end else if (em_valid && vert.ready) begin
        em_cnt <= (em_cnt == 3'd5) ? 3'd0 : em_cnt + 3'd1;
        if (em_cnt == 3'd5) begin
          em_valid <= 1'b0;
        end
      end
      if (s1_adv) begin
        unique case (s1_op)
          qgu_pkg::OP_FRAME: depth_now <= qgu_pkg::DEPTH_START;
          qgu_pkg::OP_END: depth_now <= (depth_now < depth_step) ? 16'd0
                                                                  : depth_now - depth_step;
          qgu_pkg::OP_TEXT: begin
            pen_x     <= coord_in(s1_cmd.pos_x);
            pen_y     <= coord_in(s1_cmd.pos_y) + coord_in(ascent);
            text_rgba <= s1_cmd.rgba;
          end
          qgu_pkg::OP_GLYPH: pen_x <= pen_x + g_adv;
          default: ;
        endcase
      end
    end
    if (s1_adv && s1_emits) begin
      em_z <= depth_now;
      if (s1_op == qgu_pkg::OP_GLYPH) begin
        em_x0   <= pen_x + g_ox;
        em_y0   <= pen_y + g_oy;
        em_w    <= g_w;
        em_h    <= g_h;
        em_u0   <= g_u0;
        em_v0   <= g_v0;
        em_u1   <= g_u1;
        em_v1   <= g_v1;
        em_tex  <= 1'b1;
        em_rgba <= text_rgba;
      end else begin
        em_x0   <= coord_in(s1_cmd.pos_x);
        em_y0   <= coord_in(s1_cmd.pos_y);
        em_w    <= coord_in(s1_cmd.size_w);
        em_h    <= coord_in(s1_cmd.size_h);
        em_u0   <= '0;
        em_v0   <= '0;
        em_u1   <= '0;
        em_v1   <= '0;
        em_tex  <= 1'b0;
        em_rgba <= s1_cmd.rgba;
      end
    end
  end

  // vertex order TL, TR, BL, BL, TR, BR
  logic use_r, use_b;
  assign use_r = (em_cnt == 3'd1) || (em_cnt == 3'd4) || (em_cnt == 3'd5);
  assign use_b = (em_cnt == 3'd2) || (em_cnt == 3'd3) || (em_cnt == 3'd5);

  assign vert.valid          = em_valid;
  assign vert.data.vert_x    = coord_out(use_r ? em_x0 + em_w : em_x0);
  assign vert.data.vert_y    = coord_out(use_b ? em_y0 + em_h : em_y0);
  assign vert.data.vert_z    = em_z;
  assign vert.data.vert_u    = use_r ? em_u1 : em_u0;
  assign vert.data.vert_v    = use_b ? em_v1 : em_v0;
  assign vert.data.textured  = em_tex;
  assign vert.data.vert_rgba = em_rgba;
  assign vert.data.quad_last = (em_cnt == 3'd5);

endmodule

@@ rtl/qgu_checker.sv @@
`include "text_and_rect_quad_generator_unit_assert.svh"

module qgu_checker (
  input logic clk,
  input logic rst,
  input logic vert_valid,
  input logic vert_ready,
  input logic vert_last
);

  // A stalled word stays offered.
  `QGU_ASSERT(a_vert_hold, clk, rst, vert_valid && !vert_ready |=> vert_valid, "vertex dropped")
  // Inside a quad the remaining vertices follow without a gap.
  `QGU_ASSERT(a_quad_run, clk, rst, vert_valid && vert_ready && !vert_last |=> vert_valid, "quad broken")
  // Nothing is offered in the cycle after reset.
  `QGU_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !vert_valid, "output valid after reset")

endmodule

bind text_and_rect_quad_generator_unit qgu_checker u_qgu_checker (
  .clk(clk),
  .rst(rst),
  .vert_valid(vert.valid),
  .vert_ready(vert.ready),
  .vert_last(vert.data.quad_last)
);
